[hw/rtl/lcxb_pkg.sv]
// Shared constants and types for the chained XOR byte cipher.
package lcxb_pkg;

  localparam int LUT_DEPTH_DEF = 512;
  localparam int LUT_SCALE_DEF = 256;

  // Key entry index width covers the largest supported table (4096 entries).
  localparam int IDX_W = 12;

  // Key table write from the fill generator
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [7:0]       key;
  } key_wr_t;

endpackage

[hw/rtl/lcxb_in_if.sv]
// Input byte channel: valid/ready handshake with the byte and its controls.
interface lcxb_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, action, data_byte, first_byte, input ready);
  modport sink (input valid, action, data_byte, first_byte, output ready);
endinterface

[hw/rtl/lcxb_out_if.sv]
// Result channel: valid/ready handshake with the output byte and overrun flag.
interface lcxb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       table_overrun;

  modport source (output valid, out_byte, table_overrun, input ready);
  modport sink (input valid, out_byte, table_overrun, output ready);
endinterface

[hw/rtl/lut_chained_xor_byte_cipher_unit.sv]
// Top level of the chained XOR byte cipher with generator-filled key table.
//
//   channel | port    | dir | payload
//   --------+---------+-----+-----------------------------------------
//   input   | in_if   | in  | action, data_byte, first_byte
//   result  | out_if  | out | out_byte, table_overrun
//
// One byte per cycle sustained while results are taken. The key pair for
// a byte is one read of the even/odd key memories, taken at acceptance;
// the chain XOR closes as the byte leaves the read stage. After reset the
// table fills at one entry a cycle, and ready stays low until the fill is
// done. A stalled result holds the output register while one more
// transaction waits in the read stage; beyond that, ready drops.
module lut_chained_xor_byte_cipher_unit #(
  parameter int LUT_DEPTH = lcxb_pkg::LUT_DEPTH_DEF,
  parameter int LUT_SCALE = lcxb_pkg::LUT_SCALE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lcxb_in_if.sink     in_if,
  lcxb_out_if.source  out_if
);
  import lcxb_pkg::*;

  localparam int NPAIR = LUT_DEPTH / 2;
  localparam int AW    = (NPAIR > 1) ? $clog2(NPAIR) : 1;
  localparam int PW    = $clog2(NPAIR + 1);

  key_wr_t          key_wr;
  logic             fill_done;
  logic [IDX_W-1:0] wr_pair;
  logic             wr_pair_ok;

  logic [7:0] key_even_mem [NPAIR];
  logic [7:0] key_odd_mem  [NPAIR];
  logic [7:0] rd_even_r;
  logic [7:0] rd_odd_r;

  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_nxt;
  logic [PW-1:0] eff_pos;
  logic [PW-1:0] rd_pos;
  logic [AW-1:0] rd_addr;
  logic          pos_ovr;
  logic          in_acc;

  logic       s1_vld_r;
  logic       s1_action_r;
  logic [7:0] s1_data_r;
  logic       s1_first_r;
  logic       s1_ovr_r;
  logic       adv1;

  logic [7:0] chain_r;
  logic [7:0] chain_nxt;
  logic [7:0] chain_use;
  logic [7:0] result;
  logic [7:0] cipher;

  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic       out_ovr_r;

  lcxb_keygen #(
    .LUT_DEPTH (LUT_DEPTH),
    .LUT_SCALE (LUT_SCALE)
  ) u_keygen (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_o   (key_wr),
    .done_o (fill_done)
  );

  // Drop the unpaired top entry of an odd-sized table
  assign wr_pair    = key_wr.idx >> 1;
  assign wr_pair_ok = 32'(wr_pair) < 32'(NPAIR);

  // Wrap to the first pair when no whole pair is left
  assign eff_pos = in_if.first_byte ? '0 : pos_r;
  assign pos_ovr = (32'(eff_pos) >= 32'(NPAIR));
  assign rd_pos  = pos_ovr ? '0 : eff_pos;
  assign rd_addr = rd_pos[AW-1:0];
  assign pos_nxt = rd_pos + PW'(1);

  assign adv1        = !out_vld_r || out_if.ready;
  assign in_if.ready = fill_done && (!s1_vld_r || adv1);
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (key_wr.vld && wr_pair_ok && !key_wr.idx[0]) begin
      key_even_mem[wr_pair[AW-1:0]] <= key_wr.key;
    end
    if (in_acc) begin
      rd_even_r <= key_even_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr.vld && wr_pair_ok && key_wr.idx[0]) begin
      key_odd_mem[wr_pair[AW-1:0]] <= key_wr.key;
    end
    if (in_acc) begin
      rd_odd_r <= key_odd_mem[rd_addr];
    end
  end

  assign chain_use = s1_first_r ? 8'h00 : chain_r;
  assign result    = s1_data_r ^ rd_even_r ^ chain_use;
  assign cipher    = s1_action_r ? s1_data_r : result;
  assign chain_nxt = cipher ^ rd_odd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      chain_r   <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_r <= pos_nxt;
      end
      if (adv1) begin
        s1_vld_r  <= in_acc;
        out_vld_r <= s1_vld_r;
        if (s1_vld_r) begin
          chain_r <= chain_nxt;
        end
      end else if (in_acc) begin
        s1_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_if.action;
      s1_data_r   <= in_if.data_byte;
      s1_first_r  <= in_if.first_byte;
      s1_ovr_r    <= pos_ovr;
    end
    if (adv1 && s1_vld_r) begin
      out_byte_r <= result;
      out_ovr_r  <= s1_ovr_r;
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.out_byte      = out_byte_r;
  assign out_if.table_overrun = out_ovr_r;

  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> fill_done) else $error("transaction accepted during table fill");
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) <= 32'(NPAIR)) else $error("key position out of range");
  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !adv1) |=> (s1_vld_r && $stable(rd_even_r) && $stable(rd_odd_r)))
    else $error("key read lost under stall");
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r)) else $error("result without transaction");

endmodule

[hw/rtl/lcxb_keygen.sv]
// Key table fill: minimal-standard generator and scaling, one entry per cycle.
module lcxb_keygen #(
  parameter int LUT_DEPTH = lcxb_pkg::LUT_DEPTH_DEF,
  parameter int LUT_SCALE = lcxb_pkg::LUT_SCALE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  output lcxb_pkg::key_wr_t wr_o,
  output logic             done_o
);
  import lcxb_pkg::*;

  localparam int          CW      = $clog2(LUT_DEPTH + 1);
  localparam int          PROD_W  = 46;
  localparam logic [30:0] PM_MOD  = 31'h7fffffff;
  localparam logic [14:0] PM_MUL  = 15'd16807;
  localparam logic [30:0] PM_SEED = 31'h000a2c2a;

  // s * 16807 mod (2^31 - 1), folded on the Mersenne modulus
  function automatic logic [30:0] pm_next(input logic [30:0] s);
    logic [PROD_W-1:0] p;
    logic [31:0]       sum;
    p   = PROD_W'(s) * PROD_W'(PM_MUL);
    sum = 32'(p[30:0]) + 32'(p[45:31]);
    if (sum >= {1'b0, PM_MOD}) begin
      sum = sum - {1'b0, PM_MOD};
    end
    return sum[30:0];
  endfunction

  // floor(x / (2^31 - 1)) for x below 2^46, low byte kept
  function automatic logic [7:0] mod_quot(input logic [PROD_W-1:0] x);
    logic [14:0] q0;
    logic [31:0] rem;
    logic [14:0] q;
    q0  = x[45:31];
    rem = 32'(x[30:0]) + 32'(q0);
    q   = (rem >= {1'b0, PM_MOD}) ? q0 + 15'd1 : q0;
    return q[7:0];
  endfunction

  // Start from the first draw so the top entry uses one generator step
  localparam logic [30:0] PM_SEED1 = pm_next(PM_SEED);

  logic [CW-1:0]     cnt_r;
  logic [30:0]       seed_r;
  logic              s1_vld_r;
  logic              s2_vld_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [IDX_W-1:0]  s2_idx_r;
  logic [PROD_W-1:0] prod_r;
  logic [7:0]        key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= CW'(LUT_DEPTH);
      seed_r   <= PM_SEED1;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= (cnt_r != '0);
      s2_vld_r <= s1_vld_r;
      if (cnt_r != '0) begin
        cnt_r  <= cnt_r - CW'(1);
        seed_r <= pm_next(seed_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= IDX_W'(cnt_r - CW'(1));
    s2_idx_r <= s1_idx_r;
    prod_r   <= PROD_W'(seed_r) * PROD_W'(LUT_SCALE);
    key_r    <= mod_quot(prod_r);
  end

  assign wr_o.vld = s2_vld_r;
  assign wr_o.idx = s2_idx_r;
  assign wr_o.key = key_r;
  assign done_o   = (cnt_r == '0) && !s1_vld_r && !s2_vld_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_o |=> done_o) else $error("fill done dropped");
  a_seed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    seed_r != '0) else $error("generator seed reached zero");
  a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    wr_o.vld |-> (32'(wr_o.idx) < 32'(LUT_DEPTH)))
    else $error("key write beyond table");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the chained XOR byte cipher unit.
module tb;
  import lcxb_pkg::*;

  localparam int     LUT_DEPTH = LUT_DEPTH_DEF;
  localparam longint LUT_SCALE = LUT_SCALE_DEF;
  localparam longint PM_MOD    = 64'h7fffffff;
  localparam longint PM_MUL    = 16807;
  localparam longint PM_Q      = 64'h1f31d;
  localparam longint PM_R      = 2836;
  localparam longint PM_SEED   = 64'ha2c2a;

  typedef enum logic {
    ENCRYPT = 1'b0,
    DECRYPT = 1'b1
  } cipher_op_e;

  typedef struct packed {
    cipher_op_e op;
    logic [7:0] data;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       overrun;
  } cipher_result_t;

  logic clk;
  logic rst_n;

  lcxb_in_if  in_if();
  lcxb_out_if out_if();

  lut_chained_xor_byte_cipher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Cipher state mirrored by the testbench
  logic [7:0] key_bytes [LUT_DEPTH];
  logic [7:0] chain_byte;
  int         pair_pos;

  byte_item_t     byte_q[$];
  cipher_result_t pending_cipher_q[$];

  int   error_count;
  int   bytes_accepted;
  int   results_checked;
  int   overruns_checked;
  int   decrypts_accepted;
  int   tx_idle;
  int   rx_idle;
  logic calm;
  logic hold_off;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic cipher_result_t cipher_byte(byte_item_t it);
    cipher_result_t r;
    logic [7:0]     ct;
    r.overrun = 1'b0;
    if (it.first) begin
      chain_byte = 8'h00;
      pair_pos   = 0;
    end
    // No whole key pair left: wrap to the first pair of the table
    if (pair_pos + 1 >= LUT_DEPTH) begin
      pair_pos  = 0;
      r.overrun = 1'b1;
    end
    r.out_byte = it.data ^ key_bytes[pair_pos] ^ chain_byte;
    ct         = (it.op == DECRYPT) ? it.data : r.out_byte;
    chain_byte = ct ^ key_bytes[pair_pos + 1];
    pair_pos   = pair_pos + 2;
    return r;
  endfunction

  function automatic void queue_byte(cipher_op_e op, logic [7:0] d, logic f);
    byte_item_t it;
    it.op    = op;
    it.data  = d;
    it.first = f;
    byte_q.push_back(it);
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("lut_chained_xor_byte_cipher_unit verification failed");
    $finish;
  end

  // Key table fill and stimulus
  initial begin
    longint     seed;
    longint     hi;
    longint     lo;
    longint     scaled;
    int         msg_len;
    bit         mixed;
    bit         forced_long;
    cipher_op_e msg_op;

    in_if.valid      = 1'b0;
    in_if.action     = ENCRYPT;
    in_if.data_byte  = 8'h00;
    in_if.first_byte = 1'b0;
    out_if.ready     = 1'b0;
    hold_off         = 1'b0;
    calm             = 1'b0;
    error_count      = 0;
    chain_byte       = 8'h00;
    pair_pos         = 0;

    // Schrage-form minimal-standard generator, top entry first
    seed = PM_SEED;
    for (int i = LUT_DEPTH - 1; i >= 0; i--) begin
      hi   = seed / PM_Q;
      lo   = seed % PM_Q;
      seed = PM_MUL * lo - PM_R * hi;
      if (seed <= 0) seed = seed + PM_MOD;
      scaled       = (seed * LUT_SCALE) / PM_MOD;
      key_bytes[i] = scaled[7:0];
    end

    // Directed: bytes before any first mark, field extremes, mixed actions
    queue_byte(ENCRYPT, 8'h00, 1'b0);
    queue_byte(ENCRYPT, 8'hff, 1'b0);
    queue_byte(ENCRYPT, 8'h00, 1'b1);
    queue_byte(ENCRYPT, 8'hff, 1'b0);
    queue_byte(ENCRYPT, 8'ha5, 1'b0);
    queue_byte(DECRYPT, 8'h5a, 1'b0);
    queue_byte(DECRYPT, 8'hff, 1'b0);
    queue_byte(DECRYPT, 8'h00, 1'b0);
    queue_byte(ENCRYPT, 8'h80, 1'b0);
    queue_byte(DECRYPT, 8'h3c, 1'b1);
    queue_byte(DECRYPT, 8'h01, 1'b0);
    queue_byte(ENCRYPT, 8'hc3, 1'b0);
    // first mark in the middle of a message
    queue_byte(ENCRYPT, 8'h81, 1'b1);
    queue_byte(ENCRYPT, 8'h7e, 1'b0);
    queue_byte(ENCRYPT, 8'h81, 1'b1);
    queue_byte(DECRYPT, 8'hff, 1'b1);
    queue_byte(DECRYPT, 8'h00, 1'b0);
    queue_byte(ENCRYPT, 8'h55, 1'b0);
    queue_byte(DECRYPT, 8'haa, 1'b0);
    queue_byte(ENCRYPT, 8'h01, 1'b0);

    // Random messages; some run past the table end to force wraps
    forced_long = 1'b1;
    while (byte_q.size() < 720) begin
      if (forced_long) msg_len = 300;
      else if ($urandom_range(0, 7) == 0) msg_len = $urandom_range(257, 320);
      else msg_len = $urandom_range(1, 40);
      forced_long = 1'b0;
      mixed  = ($urandom_range(0, 3) == 0);
      msg_op = cipher_op_e'($urandom_range(0, 1));
      for (int k = 0; k < msg_len; k++) begin
        queue_byte(mixed ? cipher_op_e'($urandom_range(0, 1)) : msg_op,
                   8'($urandom_range(0, 255)),
                   (k == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 59) == 0));
      end
    end
  end

  // Sender
  always @(posedge clk) begin
    byte_item_t it;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      tx_idle     <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        it.op    = cipher_op_e'(in_if.action);
        it.data  = in_if.data_byte;
        it.first = in_if.first_byte;
        pending_cipher_q.push_back(cipher_byte(it));
        bytes_accepted++;
        if (it.op == DECRYPT) decrypts_accepted++;
      end
      calm <= (byte_q.size() < 100);
      // Load the next transaction only once the current one is gone
      if (!in_if.valid || in_if.ready) begin
        if (tx_idle > 0) begin
          tx_idle     <= tx_idle - 1;
          in_if.valid <= 1'b0;
        end else if (!calm && !hold_off && $urandom_range(0, 5) == 0) begin
          tx_idle     <= $urandom_range(0, 9);
          in_if.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          it               = byte_q.pop_front();
          in_if.action     <= it.op;
          in_if.data_byte  <= it.data;
          in_if.first_byte <= it.first;
          in_if.valid      <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    cipher_result_t exp;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_idle      <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_cipher_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h overrun %0b",
                                    out_if.out_byte, out_if.table_overrun));
        end else begin
          exp = pending_cipher_q.pop_front();
          if (out_if.out_byte !== exp.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h (result %0d)",
                                      out_if.out_byte, exp.out_byte, results_checked));
          if (out_if.table_overrun !== exp.overrun)
            report_mismatch($sformatf("table_overrun %0b, want %0b (result %0d)",
                                      out_if.table_overrun, exp.overrun, results_checked));
          if (exp.overrun) overruns_checked++;
        end
        results_checked++;
      end
      if (rx_idle > 0) begin
        rx_idle      <= rx_idle - 1;
        out_if.ready <= 1'b0;
      end else if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rx_idle      <= $urandom_range(0, 9);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the pipeline backs up into the input
  initial begin
    do @(posedge clk); while (results_checked < 100);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    bytes_accepted    = 0;
    results_checked   = 0;
    overruns_checked  = 0;
    decrypts_accepted = 0;
    @(posedge rst_n);
    do @(posedge clk);
    while (byte_q.size() != 0 || in_if.valid || pending_cipher_q.size() != 0);
    repeat (8) @(posedge clk);
    $display("Ran %0d bytes (%0d decrypt), checked %0d results, %0d with table wrap.",
             bytes_accepted, decrypts_accepted, results_checked, overruns_checked);
    if (error_count == 0) begin
      $display("lut_chained_xor_byte_cipher_unit verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("lut_chained_xor_byte_cipher_unit verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/lcxb_pkg.sv
hw/rtl/lcxb_in_if.sv
hw/rtl/lcxb_out_if.sv
hw/rtl/lcxb_keygen.sv
hw/rtl/lut_chained_xor_byte_cipher_unit.sv
tb/tb.sv
